/* hw/rtl/lphs_pkg.sv */
`default_nettype none
package lphs_pkg;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int START_W  = 4;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

endpackage
`default_nettype wire

/* hw/rtl/lphs_ram.sv */
`default_nettype none
module lphs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 37
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/lphs_mod.sv */
`default_nettype none
module lphs_mod
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [VALUE_W-1:0]            i_operand,
    output logic                               o_done,
    output logic [$clog2(TABLE_SIZE)-1:0]      o_slot
);

    localparam int SW = $clog2(TABLE_SIZE);

    generate
        if ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0) begin : g_pow2
            // A power-of-two size needs only the low bits of the operand.
            logic          r_done;
            logic [SW-1:0] r_slot;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_slot <= i_operand[SW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_slot = r_slot;
        end else begin : g_fold
            // The operand is folded byte by byte with the weights 2^(8i) mod
            // TABLE_SIZE, and the short sum is reduced by a reciprocal
            // multiply. The quotient estimate is at most one low, so a single
            // compare and subtract finishes the remainder.
            localparam int SUMW = SW + 10;
            localparam int K    = SUMW + SW;
            localparam int MW   = SUMW + 1;
            localparam int PW   = SUMW + MW;
            localparam int QW   = PW - K;
            localparam int RW   = SW + 1;
            localparam logic [SW-1:0]   C1    = SW'((1 << 8) % TABLE_SIZE);
            localparam logic [SW-1:0]   C2    = SW'((1 << 16) % TABLE_SIZE);
            localparam logic [SW-1:0]   C3    = SW'((1 << 24) % TABLE_SIZE);
            localparam logic [MW-1:0]   MAGIC = MW'((64'd1 << K) / 64'(TABLE_SIZE));
            localparam logic [SUMW-1:0] T_SUM = SUMW'(TABLE_SIZE);
            localparam logic [RW-1:0]   T_REM = RW'(TABLE_SIZE);

            logic [3:0]         r_stage;
            logic               r_done;
            logic [VALUE_W-1:0] r_op;
            logic [SUMW-1:0]    r_sum;
            logic [QW-1:0]      r_quot;
            logic [RW-1:0]      r_rem;
            logic [SW-1:0]      r_slot;
            logic [SUMW-1:0]    fold;
            logic [PW-1:0]      prod;

            assign fold = SUMW'(r_op[7:0])
                        + SUMW'(r_op[15:8])  * SUMW'(C1)
                        + SUMW'(r_op[23:16]) * SUMW'(C2)
                        + SUMW'(r_op[31:24]) * SUMW'(C3);
            assign prod = PW'(r_sum) * PW'(MAGIC);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stage <= '0;
                    r_done  <= 1'b0;
                end else begin
                    r_stage <= {r_stage[2:0], i_start};
                    r_done  <= r_stage[3];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_op <= i_operand;
                end
                if (r_stage[0]) begin
                    r_sum <= fold;
                end
                if (r_stage[1]) begin
                    r_quot <= prod[PW-1:K];
                end
                if (r_stage[2]) begin
                    r_rem <= RW'(r_sum - SUMW'(r_quot) * T_SUM);
                end
                if (r_stage[3]) begin
                    r_slot <= (r_rem >= T_REM) ? SW'(r_rem - T_REM) : r_rem[SW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_slot = r_slot;
        end
    endgenerate

endmodule
`default_nettype wire

/* hw/rtl/linear_probe_hash_set.sv */
`default_nettype none
// Hash set of up to TABLE_SIZE signed 32-bit values with linear probing and
// backward-shift removal. Pulse start while busy is low; busy rises on the
// next cycle for insert, remove and sample of a non-empty set, and the result
// appears on o_done for exactly one cycle with no way to stall it. Each slot
// lives in one single-port-read, single-port-write memory entry (valid bit,
// home slot, value); the probe walk reads one slot per cycle. A removal then
// walks on through each entry of the run that follows the hole, reads the
// empty slot that ends that run, and clears the last hole; a run that fills
// the rest of the table has no empty slot to read. For a table size that is
// not a power of two the home slot comes from a pipelined remainder unit
// (byte folding and a reciprocal multiply). An unknown command and a sample
// of an empty set answer on the cycle after start. After reset the block
// sweeps the memory to clear the valid bits and holds busy high until the
// sweep is over.
module linear_probe_hash_set
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [CMD_W-1:0]           i_command,
    input  wire logic signed [VALUE_W-1:0]  i_item_value,
    input  wire logic [START_W-1:0]         i_start_slot,
    output logic                            o_done,
    output logic [STATUS_W-1:0]             o_status,
    output logic signed [VALUE_W-1:0]       o_found_value,
    output logic [OCC_W-1:0]                o_occupancy
);

    localparam int SW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int EW = 1 + SW + VALUE_W;
    localparam logic [SW-1:0] LAST = SW'(TABLE_SIZE - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HOME  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_CLOSE = 3'd5;

    function automatic logic [SW-1:0] f_next(input logic [SW-1:0] a_s);
        return (a_s == LAST) ? '0 : a_s + 1'b1;
    endfunction

    // Cyclic distance from a_from forward to a_to.
    function automatic logic [SW-1:0] f_cdist(input logic [SW-1:0] a_from,
                                              input logic [SW-1:0] a_to);
        logic [SW:0] d;
        d = {1'b0, a_to} - {1'b0, a_from};
        if (d[SW]) begin
            d = d + (SW + 1)'(TABLE_SIZE);
        end
        return d[SW-1:0];
    endfunction

    logic [2:0]          r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic [SW-1:0]       r_home, n_home;
    logic [SW-1:0]       r_addr, n_addr;
    logic [SW-1:0]       r_hole, n_hole;
    logic [SW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_count, n_count;
    logic                r_done, n_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VALUE_W-1:0]  r_found, n_found;
    logic [OCC_W-1:0]    r_occ;

    logic               mod_start;
    logic [VALUE_W-1:0] mod_operand;
    logic               mod_done;
    logic [SW-1:0]      mod_slot;

    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [SW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic               e_valid;
    logic [SW-1:0]      e_home;
    logic [VALUE_W-1:0] e_value;

    assign e_valid = ram_rdata[EW-1];
    assign e_home  = ram_rdata[VALUE_W +: SW];
    assign e_value = ram_rdata[VALUE_W-1:0];

    lphs_mod #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mod_start),
        .i_operand(mod_operand),
        .o_done   (mod_done),
        .o_slot   (mod_slot)
    );

    lphs_ram #(
        .DEPTH(TABLE_SIZE),
        .WIDTH(EW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign mod_operand = (i_command == CMD_SAMPLE) ? VALUE_W'(i_start_slot)
                                                   : $unsigned(i_item_value);
    // Outside S_HOME, where the home slot is fetched, the walk fetches the slot after the one being examined.
    assign ram_raddr   = (r_state == S_HOME) ? mod_slot : f_next(r_addr);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_value   = r_value;
        n_home    = r_home;
        n_addr    = r_addr;
        n_hole    = r_hole;
        n_n       = r_n;
        n_count   = r_count;
        n_done    = 1'b0;
        n_status  = r_status;
        n_found   = r_found;
        mod_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = f_next(r_addr);
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_command;
                    n_value = $unsigned(i_item_value);
                    n_found = '0;
                    if (i_command == CMD_INSERT || i_command == CMD_REMOVE ||
                        (i_command == CMD_SAMPLE && r_count != '0)) begin
                        mod_start = 1'b1;
                        n_state   = S_HOME;
                    end else begin
                        n_done   = 1'b1;
                        n_status = (i_command == CMD_SAMPLE) ? ST_EMPTY : ST_MISS;
                    end
                end
            end
            S_HOME: begin
                if (mod_done) begin
                    n_home  = mod_slot;
                    n_addr  = mod_slot;
                    n_n     = '0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                n_addr = f_next(r_addr);
                n_n    = r_n + 1'b1;
                case (r_cmd)
                    CMD_INSERT: begin
                        if (!e_valid) begin
                            ram_we    = 1'b1;
                            ram_wdata = {1'b1, r_home, r_value};
                            n_count   = r_count + 1'b1;
                            n_status  = ST_DONE;
                            n_done    = 1'b1;
                            n_state   = S_IDLE;
                        end else if (e_value == r_value) begin
                            n_status = ST_MISS;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else if (r_n == LAST) begin
                            n_status = ST_FULL;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!e_valid || (e_value != r_value && r_n == LAST)) begin
                            n_status = ST_MISS;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else if (e_value == r_value) begin
                            n_hole  = r_addr;
                            n_count = r_count - 1'b1;
                            n_n     = SW'(1);
                            n_state = S_SHIFT;
                        end
                    end
                    default: begin
                        if (e_valid) begin
                            n_found  = e_value;
                            n_status = ST_DONE;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else if (r_n == LAST) begin
                            n_status = ST_EMPTY;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                endcase
            end
            S_SHIFT: begin
                n_addr = f_next(r_addr);
                n_n    = r_n + 1'b1;
                if (!e_valid) begin
                    n_state = S_CLOSE;
                end else begin
                    // The entry may fill the hole only if the hole lies on its
                    // path from the home slot.
                    if (f_cdist(e_home, r_addr) >= f_cdist(r_hole, r_addr)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_hole;
                        ram_wdata = ram_rdata;
                        n_hole    = r_addr;
                    end
                    if (r_n == LAST) begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                // The last hole of the shift is only now marked empty.
                ram_we    = 1'b1;
                ram_waddr = r_hole;
                n_status  = ST_DONE;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_done  <= n_done;
            if (n_done) begin
                r_occ <= OCC_W'(n_count);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_value  <= n_value;
        r_home   <= n_home;
        r_hole   <= n_hole;
        r_n      <= n_n;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_value = $signed(r_found);
    assign o_occupancy   = r_occ;

endmodule
`default_nettype wire

/* hw/rtl/lphs_chk.sv */
`default_nettype none
module lphs_chk
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = 16
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_done,
    input wire logic [STATUS_W-1:0]        o_status,
    input wire logic signed [VALUE_W-1:0]  o_found_value,
    input wire logic [OCC_W-1:0]           o_occupancy
);

    // A result beat only follows a cycle with work in flight or a new command.
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result beat without a command");

    a_found_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_DONE) |-> (o_found_value == 0))
        else $error("found value on a failed operation");

    a_empty_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |-> (o_occupancy == 0))
        else $error("empty status with stored values");

    a_occ_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (TABLE_SIZE > 31 || 32'(o_occupancy) <= TABLE_SIZE))
        else $error("occupancy beyond table size");

    a_miss_keeps_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_MISS) |-> $stable(o_occupancy))
        else $error("occupancy changed on a miss");

endmodule

bind linear_probe_hash_set lphs_chk #(.TABLE_SIZE(TABLE_SIZE)) u_lphs_chk (.*);
`default_nettype wire

/* dv/lphs_checker.sv */
`timescale 1ns / 1ps

// Watches the command and result channels of linear_probe_hash_set, keeps its
// own copy of the table, and compares every result beat with the oldest
// expectation in order.
module lphs_checker
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic [CMD_W-1:0]      i_command,
    input  wire logic [VALUE_W-1:0]    i_item_value,
    input  wire logic [START_W-1:0]    i_start_slot,
    input  wire logic                  i_done,
    input  wire logic [STATUS_W-1:0]   i_status,
    input  wire logic [VALUE_W-1:0]    i_found_value,
    input  wire logic [OCC_W-1:0]      i_occupancy,
    output int                         o_mismatches,
    output int                         o_outstanding,
    output int                         o_checked,
    output int                         o_full_hits,
    output int                         o_empty_hits
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  found;
        logic [OCC_W-1:0]    occupancy;
    } t_set_reply;

    logic [VALUE_W-1:0] slot_val [TABLE_SIZE];
    bit                 slot_used [TABLE_SIZE];
    int unsigned        live_count;

    t_set_reply         pending_replies [$];
    t_set_reply         want;
    t_set_reply         fresh;
    int                 fails;
    int                 checked;
    int                 full_hits;
    int                 empty_hits;

    function automatic int unsigned home_slot(logic [VALUE_W-1:0] value);
        return int'(value % 32'(TABLE_SIZE));
    endfunction

    function automatic int unsigned ring_dist(int unsigned from, int unsigned to);
        return (to + TABLE_SIZE - from) % TABLE_SIZE;
    endfunction

    function automatic t_set_reply apply_set_command(
        logic [CMD_W-1:0]   cmd,
        logic [VALUE_W-1:0] value,
        logic [START_W-1:0] first_slot
    );
        t_set_reply  reply;
        int unsigned s;
        int unsigned hole;
        int unsigned j;
        int unsigned n;
        bit          hit;
        reply.status = ST_MISS;
        reply.found  = '0;
        case (cmd)
            CMD_INSERT: begin
                s = home_slot(value);
                reply.status = ST_FULL;
                for (n = 0; n < TABLE_SIZE; n++) begin
                    if (!slot_used[s]) begin
                        slot_val[s]  = value;
                        slot_used[s] = 1'b1;
                        live_count++;
                        reply.status = ST_DONE;
                        break;
                    end
                    if (slot_val[s] == value) begin
                        reply.status = ST_MISS;
                        break;
                    end
                    s = (s + 1) % TABLE_SIZE;
                end
            end
            CMD_REMOVE: begin
                s   = home_slot(value);
                hit = 1'b0;
                for (n = 0; n < TABLE_SIZE; n++) begin
                    if (!slot_used[s]) break;
                    if (slot_val[s] == value) begin
                        hit = 1'b1;
                        break;
                    end
                    s = (s + 1) % TABLE_SIZE;
                end
                if (hit) begin
                    slot_used[s] = 1'b0;
                    slot_val[s]  = '0;
                    if (live_count > 0) live_count--;
                    hole = s;
                    j    = (hole + 1) % TABLE_SIZE;
                    // An entry may fill the hole only if the hole lies on its
                    // probe path, i.e. between its home slot and where it sits.
                    for (n = 1; n < TABLE_SIZE; n++) begin
                        if (!slot_used[j]) break;
                        if (ring_dist(home_slot(slot_val[j]), j) >= ring_dist(hole, j)) begin
                            slot_val[hole]  = slot_val[j];
                            slot_used[hole] = 1'b1;
                            slot_used[j]    = 1'b0;
                            slot_val[j]     = '0;
                            hole = j;
                        end
                        j = (j + 1) % TABLE_SIZE;
                    end
                    reply.status = ST_DONE;
                end
            end
            CMD_SAMPLE: begin
                reply.status = ST_EMPTY;
                if (live_count != 0) begin
                    s = first_slot % TABLE_SIZE;
                    for (n = 0; n < TABLE_SIZE; n++) begin
                        if (slot_used[s]) begin
                            reply.found  = slot_val[s];
                            reply.status = ST_DONE;
                            break;
                        end
                        s = (s + 1) % TABLE_SIZE;
                    end
                end
            end
            default: begin
                reply.status = ST_MISS;
            end
        endcase
        reply.occupancy = live_count[OCC_W-1:0];
        return reply;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slot_used[k]) begin
                slot_used[k] = 1'b0;
                slot_val[k]  = '0;
            end
            live_count = 0;
            pending_replies.delete();
            fails      = 0;
            checked    = 0;
            full_hits  = 0;
            empty_hits = 0;
        end else begin
            if (i_done) begin
                if (pending_replies.size() == 0) begin
                    fails++;
                    $display("%0t: result beat with nothing expected, got status %0d value %0d occupancy %0d",
                             $time, i_status, $signed(i_found_value), i_occupancy);
                end else begin
                    want = pending_replies.pop_front();
                    checked++;
                    if (i_status !== want.status) begin
                        fails++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, i_status);
                    end
                    if (i_found_value !== want.found) begin
                        fails++;
                        $display("%0t: found value mismatch, expected %0d, got %0d",
                                 $time, $signed(want.found), $signed(i_found_value));
                    end
                    if (i_occupancy !== want.occupancy) begin
                        fails++;
                        $display("%0t: occupancy mismatch, expected %0d, got %0d",
                                 $time, want.occupancy, i_occupancy);
                    end
                end
            end
            if (i_start && !i_busy) begin
                fresh = apply_set_command(i_command, i_item_value, i_start_slot);
                pending_replies = {pending_replies, fresh};
                if (fresh.status == ST_FULL) full_hits++;
                if (fresh.status == ST_EMPTY) empty_hits++;
            end
        end
        o_mismatches  <= fails;
        o_outstanding <= pending_replies.size();
        o_checked     <= checked;
        o_full_hits   <= full_hits;
        o_empty_hits  <= empty_hits;
    end

endmodule

/* dv/tb_linear_probe_hash_set.sv */
`timescale 1ns / 1ps

module tb_linear_probe_hash_set;
    import lphs_pkg::*;

    localparam int TABLE_SIZE = 16;
    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 64;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [CMD_W-1:0]       command;
    logic [VALUE_W-1:0]     item_value;
    logic [START_W-1:0]     start_slot;
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic [VALUE_W-1:0]     found_value;
    logic [OCC_W-1:0]       occupancy;

    int mismatches;
    int outstanding;
    int checked;
    int full_hits;
    int empty_hits;

    int cycles;
    bit calm;
    int n_insert;
    int n_remove;
    int n_sample;
    int n_other;

    logic [VALUE_W-1:0] value_pool [32];

    linear_probe_hash_set #(
        .TABLE_SIZE(TABLE_SIZE)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .start(start),
        .busy(busy),
        .i_command(command),
        .i_item_value(item_value),
        .i_start_slot(start_slot),
        .o_done(done),
        .o_status(status),
        .o_found_value(found_value),
        .o_occupancy(occupancy)
    );

    lphs_checker #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_checker (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_command(command),
        .i_item_value(item_value),
        .i_start_slot(start_slot),
        .i_done(done),
        .i_status(status),
        .i_found_value(found_value),
        .i_occupancy(occupancy),
        .o_mismatches(mismatches),
        .o_outstanding(outstanding),
        .o_checked(checked),
        .o_full_hits(full_hits),
        .o_empty_hits(empty_hits)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding", cycles, outstanding);
            $display("linear_probe_hash_set verification failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is
    // taken, with start still high so back-to-back beats need no extra edge.
    task automatic issue_command(
        input logic [CMD_W-1:0]   cmd,
        input logic [VALUE_W-1:0] value,
        input logic [START_W-1:0] slot
    );
        while (!calm && $urandom_range(99) < 8) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        command    <= cmd;
        item_value <= value;
        start_slot <= slot;
        do begin
            @(posedge clk);
        end while (busy);
        @(negedge clk);
        case (cmd)
            CMD_INSERT: n_insert++;
            CMD_REMOVE: n_remove++;
            CMD_SAMPLE: n_sample++;
            default:    n_other++;
        endcase
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
    endtask

    initial begin
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] tmp;
        int                 draw;
        bit                 filling;

        cycles     = 0;
        calm       = 1'b0;
        n_insert   = 0;
        n_remove   = 0;
        n_sample   = 0;
        n_other    = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = CMD_INSERT;
        item_value = '0;
        start_slot = '0;

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'hFFFF_FFFF;
        value_pool[3] = 32'h0000_0000;
        for (int i = 4; i < 32; i++) begin
            tmp = $urandom();
            // Half of the random entries share home slots 2 to 5 to build long runs.
            if (i % 2 == 1) tmp[3:0] = 4'($urandom_range(2, 5));
            value_pool[i] = tmp;
        end

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty set, unknown code, wrap-around at the table end,
        // duplicate insert, backward shift across the wrap, and a full table.
        issue_command(CMD_SAMPLE, 32'h1234_5678, 4'd7);
        issue_command(CMD_UNUSED, 32'hDEAD_BEEF, 4'd15);
        issue_command(CMD_REMOVE, 32'h0000_0009, 4'd0);
        issue_command(CMD_INSERT, 32'h0000_0000, 4'd0);
        issue_command(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        issue_command(CMD_INSERT, 32'h7FFF_FFFF, 4'd0);
        issue_command(CMD_INSERT, 32'h8000_0000, 4'd0);
        issue_command(CMD_INSERT, 32'h0000_0000, 4'd0);
        issue_command(CMD_SAMPLE, 32'h0000_0000, 4'd15);
        issue_command(CMD_REMOVE, 32'h0000_0000, 4'd0);
        for (int k = 0; k < 13; k++) begin
            issue_command(CMD_INSERT, 32'h0000_0005 + 32'(k * 16), 4'($urandom_range(15)));
        end
        issue_command(CMD_INSERT, 32'h0000_1234, 4'd0);
        issue_command(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 300 && n < 500);
            if (n == 650) drain_results();
            if (n % 50 == 49) begin
                value_pool[$urandom_range(31, 4)] = $urandom();
            end
            // Alternate long fill-heavy and drain-heavy stretches so the
            // table swings between empty and full.
            filling = ((n / 120) % 2 == 0);
            draw = $urandom_range(99);
            if (draw < 3) cmd = CMD_UNUSED;
            else if (draw < 20) cmd = CMD_SAMPLE;
            else if (draw < (filling ? 72 : 40)) cmd = CMD_INSERT;
            else cmd = CMD_REMOVE;
            if (cmd == CMD_SAMPLE || cmd == CMD_UNUSED || $urandom_range(9) == 0) begin
                value = $urandom();
            end else begin
                value = value_pool[$urandom_range(31)];
            end
            issue_command(cmd, value, 4'($urandom_range(15)));
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Run covered %0d commands: %0d insert, %0d remove, %0d sample, %0d unused code",
                 n_insert + n_remove + n_sample + n_other, n_insert, n_remove, n_sample, n_other);
        $display("%0d results checked, %0d table-full and %0d empty-set answers, %0d mismatches",
                 checked, full_hits, empty_hits, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("linear_probe_hash_set verification clean");
        end else begin
            $display("linear_probe_hash_set verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lphs_pkg.sv
hw/rtl/lphs_ram.sv
hw/rtl/lphs_mod.sv
hw/rtl/linear_probe_hash_set.sv
hw/rtl/lphs_chk.sv
dv/lphs_checker.sv
dv/tb_linear_probe_hash_set.sv
